### hw/rtl/skts_pkg.sv
// Shared types and constants for the scalar Kalman trajectory smoother.
// No dependencies; used by skts_lane, skts_gain and the top level.
package skts_pkg;

  localparam int RegW   = 24;
  localparam int VarW   = 25;
  localparam int StepW  = 32;
  localparam int AccW   = 48;
  localparam int DiffW  = 49;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MEASUREMENT_NOISE = 2'd1;

  localparam logic signed [AccW-1:0]  Max48 = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0]  Min48 = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [StepW-1:0] Max32 = {1'b0, {(StepW-1){1'b1}}};
  localparam logic signed [StepW-1:0] Min32 = {1'b1, {(StepW-1){1'b0}}};

  typedef struct packed {
    logic accept;
    logic diff;
    logic mult;
    logic update;
    logic first;
  } seq_ctrl_t;

endpackage

### hw/rtl/scalar_kalman_trajectory_smoother.sv
// Scalar Kalman trajectory smoother: three axis lanes and one shared gain unit.
// Sequence: S_DIFF, S_DIV, S_MULT, S_UPDATE, S_OUT; the first frame skips S_DIV and S_MULT.
// One transaction at a time: in_stall holds input off until the sequence returns to S_IDLE.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst, synchronous): zero trajectory and estimate, variance 1.0, default Q and R.
// Depends on skts_pkg, skts_lane, skts_gain.
module scalar_kalman_trajectory_smoother #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [skts_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [skts_pkg::RegW-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                motion_valid,
  input  logic signed [skts_pkg::StepW-1:0]   step_x,
  input  logic signed [skts_pkg::StepW-1:0]   step_y,
  input  logic signed [skts_pkg::StepW-1:0]   step_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [skts_pkg::StepW-1:0]   corrected_x,
  output logic signed [skts_pkg::StepW-1:0]   corrected_y,
  output logic signed [skts_pkg::StepW-1:0]   corrected_angle,
  output logic signed [skts_pkg::AccW-1:0]    smoothed_x,
  output logic signed [skts_pkg::AccW-1:0]    smoothed_y,
  output logic signed [skts_pkg::AccW-1:0]    smoothed_angle
);

  localparam logic [skts_pkg::RegW-1:0] QReset =
    skts_pkg::RegW'((64'd262 << FRAC_BITS) >> 16);
  localparam logic [skts_pkg::RegW-1:0] RReset =
    skts_pkg::RegW'(64'd1 << (FRAC_BITS - 2));

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIFF   = 6'b000010,
    S_DIV    = 6'b000100,
    S_MULT   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   first;
  logic [skts_pkg::RegW-1:0] process_noise;
  logic [skts_pkg::RegW-1:0] measurement_noise;

  skts_pkg::seq_ctrl_t ctrl;
  logic                 accept;
  logic                 out_free;
  logic                 gain_busy;
  logic [FRAC_BITS:0]   gain;

  logic signed [skts_pkg::StepW-1:0] lane_step [3];
  logic signed [skts_pkg::AccW-1:0]  lane_est  [3];
  logic signed [skts_pkg::StepW-1:0] lane_corr [3];

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign lane_step[0] = step_x;
  assign lane_step[1] = step_y;
  assign lane_step[2] = step_angle;

  always_comb begin
    ctrl.accept = accept;
    ctrl.diff   = state == S_DIFF;
    ctrl.mult   = state == S_MULT;
    ctrl.update = state == S_UPDATE;
    ctrl.first  = first;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_DIFF;
      S_DIFF:   state_next = first ? S_UPDATE : S_DIV;
      S_DIV:    if (!gain_busy) state_next = S_MULT;
      S_MULT:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      first             <= 1'b1;
      out_valid         <= 1'b0;
      process_noise     <= QReset;
      measurement_noise <= RReset;
    end else begin
      state <= state_next;
      if (state == S_UPDATE) begin
        first <= 1'b0;
      end
      if (cfg_write_en) begin
        case (cfg_index)
          skts_pkg::REG_PROCESS_NOISE:     process_noise     <= cfg_data;
          skts_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      corrected_x     <= lane_corr[0];
      corrected_y     <= lane_corr[1];
      corrected_angle <= lane_corr[2];
      smoothed_x      <= lane_est[0];
      smoothed_y      <= lane_est[1];
      smoothed_angle  <= lane_est[2];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    skts_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .motion_valid (motion_valid),
      .step_in      (lane_step[i]),
      .gain         (gain),
      .est          (lane_est[i]),
      .corrected    (lane_corr[i])
    );
  end

  skts_gain #(
    .FRAC_BITS (FRAC_BITS)
  ) u_gain (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .process_noise     (process_noise),
    .measurement_noise (measurement_noise),
    .gain              (gain),
    .busy              (gain_busy)
  );

  a_mult_after_div: assert property (@(posedge clk) disable iff (rst)
    state == S_MULT |-> !gain_busy)
    else $error("gain used while divider still running");

  a_first_once: assert property (@(posedge clk) disable iff (rst)
    $fell(first) |-> $past(state == S_UPDATE))
    else $error("first-frame flag cleared outside update");

  a_div_started: assert property (@(posedge clk) disable iff (rst)
    state == S_DIFF && !first |=> gain_busy)
    else $error("divider did not start for a transaction");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall && state == S_DIFF)
    else $error("transaction accepted without entering the sequence");

endmodule

### hw/rtl/skts_lane.sv
// One axis lane: step selection, saturating trajectory, Kalman estimate, correction.
// Depends on skts_pkg.
module skts_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  skts_pkg::seq_ctrl_t            ctrl,
  input  logic                           motion_valid,
  input  logic signed [skts_pkg::StepW-1:0] step_in,
  input  logic [FRAC_BITS:0]             gain,
  output logic signed [skts_pkg::AccW-1:0]  est,
  output logic signed [skts_pkg::StepW-1:0] corrected
);

  localparam int ProdW = skts_pkg::DiffW + FRAC_BITS + 2;
  localparam int CorrW = skts_pkg::AccW + 2;

  logic signed [skts_pkg::StepW-1:0] last_good;
  logic signed [skts_pkg::StepW-1:0] step;
  logic signed [skts_pkg::AccW-1:0]  acc;
  logic signed [skts_pkg::DiffW-1:0] diff;
  logic signed [ProdW-1:0]           prod;

  logic signed [skts_pkg::StepW-1:0] step_sel;
  logic signed [skts_pkg::DiffW-1:0] acc_sum;
  logic signed [skts_pkg::AccW-1:0]  acc_next;
  logic signed [FRAC_BITS+1:0]       gain_s;
  logic signed [ProdW-1:0]           prod_next;
  logic signed [ProdW-1:0]           delta;
  logic signed [CorrW-1:0]           corr_sum;

  always_comb begin
    step_sel = motion_valid ? step_in : last_good;
    acc_sum  = {acc[skts_pkg::AccW-1], acc}
             + {{(skts_pkg::DiffW-skts_pkg::StepW){step_sel[skts_pkg::StepW-1]}}, step_sel};
    if (acc_sum[skts_pkg::DiffW-1] != acc_sum[skts_pkg::AccW-1]) begin
      acc_next = acc_sum[skts_pkg::DiffW-1] ? skts_pkg::Min48 : skts_pkg::Max48;
    end else begin
      acc_next = acc_sum[skts_pkg::AccW-1:0];
    end
    gain_s    = {1'b0, gain};
    prod_next = ProdW'(diff) * ProdW'(gain_s);
    delta     = prod >>> FRAC_BITS;
    corr_sum  = {{(CorrW-skts_pkg::StepW){step[skts_pkg::StepW-1]}}, step}
              + {{2{est[skts_pkg::AccW-1]}}, est}
              - {{2{acc[skts_pkg::AccW-1]}}, acc};
    if (corr_sum[CorrW-1:skts_pkg::StepW-1] != {(CorrW-skts_pkg::StepW+1){1'b0}} &&
        corr_sum[CorrW-1:skts_pkg::StepW-1] != {(CorrW-skts_pkg::StepW+1){1'b1}}) begin
      corrected = corr_sum[CorrW-1] ? skts_pkg::Min32 : skts_pkg::Max32;
    end else begin
      corrected = corr_sum[skts_pkg::StepW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_good <= '0;
      acc       <= '0;
      est       <= '0;
    end else begin
      if (ctrl.accept) begin
        if (motion_valid) begin
          last_good <= step_in;
        end
        acc <= acc_next;
      end
      if (ctrl.update) begin
        est <= ctrl.first ? '0 : est + delta[skts_pkg::AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      step <= step_sel;
    end
    if (ctrl.diff) begin
      diff <= {acc[skts_pkg::AccW-1], acc} - {est[skts_pkg::AccW-1], est};
    end
    if (ctrl.mult) begin
      prod <= prod_next;
    end
  end

endmodule

### hw/rtl/skts_gain.sv
// Shared gain unit: error variance, predicted variance and restoring gain divider.
// Depends on skts_pkg.
module skts_gain #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  skts_pkg::seq_ctrl_t         ctrl,
  input  logic [skts_pkg::RegW-1:0]   process_noise,
  input  logic [skts_pkg::RegW-1:0]   measurement_noise,
  output logic [FRAC_BITS:0]          gain,
  output logic                        busy
);

  localparam int VarW  = skts_pkg::VarW;
  localparam int DenW  = VarW + 1;
  localparam int CntW  = $clog2(FRAC_BITS + 2);
  localparam int PprodW = FRAC_BITS + 1 + VarW;
  localparam logic [CntW-1:0]      CntInit = CntW'(FRAC_BITS + 1);
  localparam logic [VarW-1:0]      OneVar  = VarW'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   OneK    = {1'b1, {FRAC_BITS{1'b0}}};

  logic [VarW-1:0]    variance;
  logic [VarW-1:0]    pp;
  logic [DenW-1:0]    den;
  logic               den_zero;
  logic [DenW-1:0]    rem;
  logic [FRAC_BITS:0] quo;
  logic [CntW-1:0]    cnt;
  logic [PprodW-1:0]  pprod;

  logic [DenW-1:0]    pp_sum;
  logic [VarW-1:0]    pp_sat;
  logic [DenW-1:0]    den_next;
  logic               bit_in;
  logic [DenW:0]      trial;
  logic               ge;

  always_comb begin
    pp_sum   = {1'b0, variance} + DenW'(process_noise);
    pp_sat   = pp_sum[DenW-1] ? {VarW{1'b1}} : pp_sum[VarW-1:0];
    den_next = {1'b0, pp_sat} + DenW'(measurement_noise);
    bit_in   = (cnt == CntInit) ? pp[0] : 1'b0;
    trial    = {rem, bit_in};
    ge       = trial >= {1'b0, den};
    gain     = den_zero ? '0 : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      variance <= OneVar;
      busy     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (ctrl.diff && !ctrl.first) begin
        busy <= 1'b1;
        cnt  <= CntInit;
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
        end
      end
      if (ctrl.update) begin
        variance <= ctrl.first ? OneVar : pprod[FRAC_BITS +: VarW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff && !ctrl.first) begin
      pp       <= pp_sat;
      den      <= den_next;
      den_zero <= den_next == '0;
      rem      <= DenW'(pp_sat >> 1);
      quo      <= '0;
    end else if (busy) begin
      rem <= ge ? DenW'(trial - {1'b0, den}) : trial[DenW-1:0];
      quo <= {quo[FRAC_BITS-1:0], ge};
    end
    if (ctrl.mult) begin
      pprod <= PprodW'(OneK - gain) * PprodW'(pp);
    end
  end

endmodule

### verif/scalar_kalman_trajectory_smoother_test.sv
// Self-checking testbench for scalar_kalman_trajectory_smoother: motion items go in,
// smoothed trajectory and corrected motion come out and are checked against a predictor.
// Depends on skts_pkg and the scalar_kalman_trajectory_smoother RTL only.
module scalar_kalman_trajectory_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 16;
  localparam int TimeoutNs = 100_000_000;
  localparam logic [63:0] OneFx = 64'd1 << FracBits;
  localparam logic [63:0] VarMax = (64'd1 << skts_pkg::VarW) - 1;
  localparam logic [skts_pkg::RegW-1:0] RegMax = {skts_pkg::RegW{1'b1}};
  localparam logic [skts_pkg::RegW-1:0] DefaultProcessNoise = 24'd262;
  localparam logic [skts_pkg::RegW-1:0] DefaultMeasurementNoise = 24'd16384;
  localparam logic [skts_pkg::CfgIdxW-1:0] REG_SPARE_LOW = 2'd2;
  localparam logic [skts_pkg::CfgIdxW-1:0] REG_SPARE_HIGH = 2'd3;

  typedef struct packed {
    logic [2:0][skts_pkg::StepW-1:0] corrected;
    logic [2:0][skts_pkg::AccW-1:0]  smoothed;
  } motion_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [skts_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [skts_pkg::RegW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic motion_valid = 1'b0;
  logic signed [skts_pkg::StepW-1:0] step_x = '0;
  logic signed [skts_pkg::StepW-1:0] step_y = '0;
  logic signed [skts_pkg::StepW-1:0] step_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [skts_pkg::StepW-1:0] corrected_x;
  logic signed [skts_pkg::StepW-1:0] corrected_y;
  logic signed [skts_pkg::StepW-1:0] corrected_angle;
  logic signed [skts_pkg::AccW-1:0] smoothed_x;
  logic signed [skts_pkg::AccW-1:0] smoothed_y;
  logic signed [skts_pkg::AccW-1:0] smoothed_angle;

  logic signed [skts_pkg::AccW-1:0]  traj_acc [3];
  logic signed [skts_pkg::AccW-1:0]  traj_est [3];
  logic signed [skts_pkg::StepW-1:0] held_step [3];
  logic [skts_pkg::VarW-1:0] est_var;
  logic first_frame;
  logic [skts_pkg::RegW-1:0] noise_q;
  logic [skts_pkg::RegW-1:0] noise_r;

  motion_result_t results_due [$];
  int error_count = 0;
  int report_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  scalar_kalman_trajectory_smoother #(
    .FRAC_BITS(FracBits)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .motion_valid(motion_valid),
    .step_x(step_x),
    .step_y(step_y),
    .step_angle(step_angle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .corrected_x(corrected_x),
    .corrected_y(corrected_y),
    .corrected_angle(corrected_angle),
    .smoothed_x(smoothed_x),
    .smoothed_y(smoothed_y),
    .smoothed_angle(smoothed_angle)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [skts_pkg::AccW-1:0] clamp48(input longint v);
    if (v > longint'(skts_pkg::Max48)) return skts_pkg::Max48;
    if (v < longint'(skts_pkg::Min48)) return skts_pkg::Min48;
    return v[skts_pkg::AccW-1:0];
  endfunction

  function automatic logic signed [skts_pkg::StepW-1:0] clamp32(input longint v);
    if (v > longint'(skts_pkg::Max32)) return skts_pkg::Max32;
    if (v < longint'(skts_pkg::Min32)) return skts_pkg::Min32;
    return v[skts_pkg::StepW-1:0];
  endfunction

  function automatic void reset_smoother_state();
    for (int i = 0; i < 3; i++) begin
      traj_acc[i] = '0;
      traj_est[i] = '0;
      held_step[i] = '0;
    end
    est_var = OneFx[skts_pkg::VarW-1:0];
    first_frame = 1'b1;
    noise_q = DefaultProcessNoise;
    noise_r = DefaultMeasurementNoise;
  endfunction

  function automatic motion_result_t predict_motion(input logic mv,
                                                    input logic [skts_pkg::StepW-1:0] sx,
                                                    input logic [skts_pkg::StepW-1:0] sy,
                                                    input logic [skts_pkg::StepW-1:0] sa);
    logic [2:0][skts_pkg::StepW-1:0] raw;
    logic [63:0] prior;
    logic [63:0] denom;
    logic [63:0] gain;
    logic [63:0] var_prod;
    logic signed [79:0] diff_w;
    logic signed [79:0] gain_w;
    logic signed [79:0] prod;
    motion_result_t res;
    raw = {sa, sy, sx};
    for (int i = 0; i < 3; i++) begin
      if (mv) held_step[i] = raw[i];
      traj_acc[i] = clamp48(longint'(traj_acc[i]) + longint'(held_step[i]));
    end
    if (first_frame) begin
      for (int i = 0; i < 3; i++) traj_est[i] = '0;
      est_var = OneFx[skts_pkg::VarW-1:0];
      first_frame = 1'b0;
    end else begin
      prior = 64'(est_var) + 64'(noise_q);
      if (prior > VarMax) prior = VarMax;
      denom = prior + 64'(noise_r);
      gain = (denom == 0) ? 64'd0 : (prior << FracBits) / denom;
      gain_w = 80'(gain);
      for (int i = 0; i < 3; i++) begin
        diff_w = 80'(longint'(traj_acc[i]) - longint'(traj_est[i]));
        prod = diff_w * gain_w;
        prod = prod >>> FracBits;
        traj_est[i] = traj_est[i] + prod[skts_pkg::AccW-1:0];
      end
      var_prod = ((OneFx - gain) * prior) >> FracBits;
      est_var = var_prod[skts_pkg::VarW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      res.corrected[i] = clamp32(longint'(held_step[i]) + longint'(traj_est[i])
                                 - longint'(traj_acc[i]));
      res.smoothed[i] = traj_est[i];
    end
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    error_count++;
    if (report_count < 10) begin
      $display("%0t: %s", $time, msg);
      report_count++;
    end
  endfunction

  function automatic void check_motion_result();
    motion_result_t got;
    motion_result_t want;
    got.corrected = {corrected_angle, corrected_y, corrected_x};
    got.smoothed = {smoothed_angle, smoothed_y, smoothed_x};
    if (results_due.size() == 0) begin
      note_failure("result with no transaction outstanding");
    end else begin
      want = results_due.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.corrected[i] !== want.corrected[i])
          note_failure($sformatf("axis %0d corrected: expected %0d, got %0d", i,
                                 $signed(want.corrected[i]), $signed(got.corrected[i])));
        if (got.smoothed[i] !== want.smoothed[i])
          note_failure($sformatf("axis %0d smoothed: expected %0d, got %0d", i,
                                 $signed(want.smoothed[i]), $signed(got.smoothed[i])));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_motion_result();
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic send_motion(input logic mv, input logic [skts_pkg::StepW-1:0] sx,
                             input logic [skts_pkg::StepW-1:0] sy,
                             input logic [skts_pkg::StepW-1:0] sa);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    motion_valid <= mv;
    step_x <= sx;
    step_y <= sy;
    step_angle <= sa;
    do @(posedge clk); while (in_stall);
    results_due.insert(results_due.size(), predict_motion(mv, sx, sy, sa));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [skts_pkg::CfgIdxW-1:0] idx,
                                input logic [skts_pkg::RegW-1:0] value);
    wait_for_results();
    repeat (FracBits + 8) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == skts_pkg::REG_PROCESS_NOISE) noise_q = value;
    else if (idx == skts_pkg::REG_MEASUREMENT_NOISE) noise_r = value;
  endtask

  function automatic logic [skts_pkg::StepW-1:0] random_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return skts_pkg::StepW'($urandom_range(2097152)) - 32'd1048576;
    if (pick < 90) return $urandom();
    case ($urandom_range(4))
      0: return skts_pkg::Max32;
      1: return skts_pkg::Min32;
      2: return '0;
      3: return '1;
      default: return 32'd1;
    endcase
  endfunction

  task automatic send_random_motion();
    send_motion($urandom_range(99) < 85, random_step(), random_step(), random_step());
  endtask

  task automatic test_directed();
    // no motion yet: reuse zeros, then first real motions at the extremes
    send_motion(1'b0, $urandom(), $urandom(), $urandom());
    send_motion(1'b0, $urandom(), $urandom(), $urandom());
    send_motion(1'b1, skts_pkg::Max32, skts_pkg::Max32, skts_pkg::Max32);
    send_motion(1'b1, skts_pkg::Min32, skts_pkg::Min32, skts_pkg::Min32);
    send_motion(1'b1, '0, '0, '0);
    send_motion(1'b0, skts_pkg::Max32, skts_pkg::Min32, '1);
    send_motion(1'b1, 32'd1, '1, 32'h0001_0000);
    send_motion(1'b0, '0, '0, '0);
    send_motion(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, skts_pkg::Min32);
  endtask

  task automatic test_gain_corners();
    // unit gain drives the variance to zero, then the denominator is zero
    write_register(skts_pkg::REG_PROCESS_NOISE, '0);
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, '0);
    repeat (3) send_motion(1'b1, 32'h0012_3456, 32'hFFF0_0000, 32'h0000_8000);
    write_register(skts_pkg::REG_PROCESS_NOISE, RegMax);
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, RegMax);
    repeat (3) send_random_motion();
    // tiny gain: the estimate lags and the correction saturates both ways
    write_register(skts_pkg::REG_PROCESS_NOISE, '0);
    repeat (4) send_motion(1'b1, skts_pkg::Max32, skts_pkg::Max32, skts_pkg::Max32);
    repeat (4) send_motion(1'b1, skts_pkg::Min32, skts_pkg::Min32, skts_pkg::Min32);
  endtask

  task automatic test_register_index();
    write_register(skts_pkg::REG_PROCESS_NOISE, DefaultProcessNoise);
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, DefaultMeasurementNoise);
    write_register(REG_SPARE_LOW, RegMax);
    write_register(REG_SPARE_HIGH, 24'h12_3456);
    repeat (3) send_random_motion();
  endtask

  task automatic test_long_drift();
    // hold a full-scale step so the trajectory runs far from the estimate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_motion(1'b1, skts_pkg::Max32, skts_pkg::Max32, skts_pkg::Max32);
    repeat (120) send_motion(1'b0, $urandom(), $urandom(), $urandom());
    repeat (4) send_motion(1'b1, skts_pkg::Min32, skts_pkg::Max32, skts_pkg::Min32);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left <= 400;
    repeat (12) send_random_motion();
    wait_for_results();
    repeat (4) send_random_motion();
    wait_for_results();
  endtask

  task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_motion();
  endtask

  task automatic test_random_traffic();
    write_register(skts_pkg::REG_PROCESS_NOISE, DefaultProcessNoise);
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, DefaultMeasurementNoise);
    run_random_phase(170, 15, 51);
    write_register(skts_pkg::REG_PROCESS_NOISE, skts_pkg::RegW'($urandom()));
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, skts_pkg::RegW'($urandom()));
    run_random_phase(170, 15, 51);
    write_register(skts_pkg::REG_PROCESS_NOISE, '0);
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, RegMax);
    run_random_phase(170, 51, 15);
    write_register(skts_pkg::REG_PROCESS_NOISE, RegMax);
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, '0);
    run_random_phase(170, 51, 15);
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, RegMax);
    run_random_phase(170, 0, 0);
    write_register(skts_pkg::REG_PROCESS_NOISE, skts_pkg::RegW'($urandom_range(1023)));
    write_register(skts_pkg::REG_MEASUREMENT_NOISE, skts_pkg::RegW'($urandom_range(131071)));
    run_random_phase(170, 0, 0);
  endtask

  initial begin
    reset_smoother_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_gain_corners();
    test_register_index();
    test_long_drift();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (FracBits + 16) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
